// ===== rtl/mwr_pkg.sv =====
package mwr_pkg;

	// Width of the command code shifted out ahead of the address
	localparam int unsigned CODE_BITS = 4;

	// Command code after reset
	localparam logic [CODE_BITS-1:0] CODE_RESET = 4'hD;

	// Item operation codes
	typedef enum logic {
		OP_START = 1'b0,
		OP_TICK  = 1'b1
	} op_t;

	// Pin and status levels reported for one item
	typedef struct packed {
		logic cs;
		logic di;
		logic busy;
		logic valid;
	} flags_t;

endpackage

// ===== rtl/mwr_engine.sv =====
module mwr_engine #(
	parameter int unsigned ADDR_BITS = 7,
	parameter int unsigned DATA_BITS = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              en,
	input  mwr_pkg::op_t                      op,
	input  logic [ADDR_BITS-1:0]              address,
	input  logic                              do_bit,
	input  logic [mwr_pkg::CODE_BITS-1:0]     cmd_code,
	output mwr_pkg::flags_t                   flags,
	output logic [DATA_BITS-1:0]              read_data
);

	localparam int unsigned CMD_BITS    = mwr_pkg::CODE_BITS + ADDR_BITS;
	localparam int unsigned TOTAL_TICKS = CMD_BITS + DATA_BITS;
	localparam int unsigned CNT_W       = $clog2(TOTAL_TICKS + 1);
	localparam logic [CNT_W-1:0] CMD_LAST  = CNT_W'(CMD_BITS);
	localparam logic [CNT_W-1:0] TICK_LAST = CNT_W'(TOTAL_TICKS);

	logic [CNT_W-1:0]     tick_q, tick_d, tick_inc;
	logic [CMD_BITS-1:0]  cmd_q, cmd_d;
	logic [DATA_BITS-1:0] data_q, data_d;
	logic                 busy_q, busy_d;
	logic                 sel_q, sel_d;
	logic                 di_d, valid_d;

	// Work out the state after this item
	always_comb begin
		tick_d   = tick_q;
		cmd_d    = cmd_q;
		data_d   = data_q;
		busy_d   = busy_q;
		sel_d    = sel_q;
		di_d     = 1'b0;
		valid_d  = 1'b0;
		tick_inc = tick_q + CNT_W'(1);
		if (op == mwr_pkg::OP_START) begin
			// start is dropped while a read is running
			if (!busy_q) begin
				busy_d = 1'b1;
				sel_d  = 1'b1;
				tick_d = '0;
				data_d = '0;
				cmd_d  = {cmd_code, address};
			end
		end else if (busy_q) begin
			if (tick_q < CMD_LAST) begin
				di_d  = cmd_q[CMD_BITS-1];
				cmd_d = {cmd_q[CMD_BITS-2:0], 1'b0};
			end else begin
				data_d = {data_q[DATA_BITS-2:0], do_bit};
			end
			tick_d = tick_inc;
			if (tick_inc >= TICK_LAST) begin
				valid_d = 1'b1;
				busy_d  = 1'b0;
				tick_d  = '0;
			end
		end
	end

	// Commit the state for each transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_q <= '0;
			cmd_q  <= '0;
			data_q <= '0;
			busy_q <= 1'b0;
			sel_q  <= 1'b0;
		end else if (en) begin
			tick_q <= tick_d;
			cmd_q  <= cmd_d;
			data_q <= data_d;
			busy_q <= busy_d;
			sel_q  <= sel_d;
		end
	end

	assign flags.cs    = sel_d;
	assign flags.di    = di_d;
	assign flags.busy  = busy_d;
	assign flags.valid = valid_d;
	assign read_data   = data_d;

`ifndef SYNTHESIS
	a_busy_selects: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> sel_q) else $error("read running without chip select");
	a_idle_count: assert property (@(posedge clk) disable iff (!arst_n)
		!busy_q |-> (tick_q == '0)) else $error("tick count not cleared when idle");
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		tick_q < TICK_LAST) else $error("tick count beyond read length");
	a_valid_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(en && flags.valid) |=> !busy_q) else $error("read still busy after word");
`endif

endmodule

// ===== rtl/microwire_eeprom_read_master.sv =====
// Microwire serial EEPROM read master.
// Input channel (in_valid/in_ready): op, address, do_bit. A start item
// (op = 0) selects the chip and loads the read code and address; a start
// during a read is dropped. Each tick item (op = 1) is one serial clock
// period: the first 4 + ADDR_BITS ticks drive di_level with the command,
// the next DATA_BITS ticks shift do_bit into read_data, MSB first, and the
// last one raises data_valid. A tick while idle changes nothing.
// Output channel (out_valid/out_ready): one result per item with
// cs_level, di_level, busy_res, data_valid and read_data.
// Config channel (cfg_valid/cfg_ready/cfg_data): the 4-bit read code,
// always ready; write it only while no read is in progress.
// An accepted item passes through the input register, then the state update into
// the result register. Throughput: one item per cycle; while a result waits at the
// output the input register takes one more item and then in_ready drops.
// Reset clears the engine state and both valid flags, lowers the engine's chip
// select and sets the read code to 0xD; input and result payloads are not reset.
// When out_ready is low the result holds and the pipeline stops after the
// input register fills.
module microwire_eeprom_read_master #(
	parameter int unsigned ADDR_BITS = 7,
	parameter int unsigned DATA_BITS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          op,
	input  logic [ADDR_BITS-1:0]          address,
	input  logic                          do_bit,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic                          cs_level,
	output logic                          di_level,
	output logic                          busy_res,
	output logic                          data_valid,
	output logic [DATA_BITS-1:0]          read_data,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [mwr_pkg::CODE_BITS-1:0] cfg_data
);

	logic                              v_s1;
	mwr_pkg::op_t                      op_s1;
	logic [ADDR_BITS-1:0]              address_s1;
	logic                              do_bit_s1;
	logic [mwr_pkg::CODE_BITS-1:0]     cmd_code_q;
	logic                              out_valid_q;
	mwr_pkg::flags_t                   flags_q, flags_c;
	logic [DATA_BITS-1:0]              data_q, data_c;
	logic                              adv;

	// Advance the input stage when the result register is free
	assign adv      = v_s1 && (!out_valid_q || out_ready);
	assign in_ready = !v_s1 || adv;

	// Hold the read code
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_code_q <= mwr_pkg::CODE_RESET;
		end else if (cfg_valid) begin
			cmd_code_q <= cfg_data;
		end
	end

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_ready) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			op_s1      <= mwr_pkg::op_t'(op);
			address_s1 <= address;
			do_bit_s1  <= do_bit;
		end
	end

	mwr_engine #(
		.ADDR_BITS(ADDR_BITS),
		.DATA_BITS(DATA_BITS)
	) u_engine (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (adv),
		.op       (op_s1),
		.address  (address_s1),
		.do_bit   (do_bit_s1),
		.cmd_code (cmd_code_q),
		.flags    (flags_c),
		.read_data(data_c)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			flags_q <= flags_c;
			data_q  <= data_c;
		end
	end

	assign out_valid  = out_valid_q;
	assign cs_level   = flags_q.cs;
	assign di_level   = flags_q.di;
	assign busy_res   = flags_q.busy;
	assign data_valid = flags_q.valid;
	assign read_data  = data_q;

endmodule
